// ----- rtl/bsq_pkg.sv -----
// Shared widths, operation and slot state codes, and command structs for the slot queue.
package bsq_pkg;

   localparam int SLOTS   = 64;
   localparam int SLOT_W  = 6;
   localparam int IDX_W   = 7;
   localparam int COUNT_W = 7;
   localparam int OP_W    = 3;
   localparam int STATE_W = 2;
   localparam int DIM_W   = 16;
   localparam int FMT_W   = 8;
   localparam int STAMP_W = 64;
   localparam int ORDER_DEPTH = 2 ** SLOT_W;

   localparam logic [IDX_W-1:0]   SLOT_LIMIT  = IDX_W'(SLOTS);
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(SLOTS);

   localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd0;
   localparam logic [OP_W-1:0] OP_QUEUE   = 3'd1;
   localparam logic [OP_W-1:0] OP_CANCEL  = 3'd2;
   localparam logic [OP_W-1:0] OP_ACQUIRE = 3'd3;
   localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;
   localparam logic [OP_W-1:0] OP_GET     = 3'd5;

   localparam logic [STATE_W-1:0] ST_FREE     = 2'd0;
   localparam logic [STATE_W-1:0] ST_DEQUEUED = 2'd1;
   localparam logic [STATE_W-1:0] ST_QUEUED   = 2'd2;
   localparam logic [STATE_W-1:0] ST_ACQUIRED = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [IDX_W-1:0]   slot;
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic [FMT_W-1:0]   pixel_format;
      logic [STAMP_W-1:0] time_ns;
      logic [STAMP_W-1:0] guest_address;
   } req_item_type;

   typedef struct packed {
      logic               wr_geom;
      logic               wr_stamp;
      logic               rd_en;
      logic               rd_get;
      logic [SLOT_W-1:0]  addr;
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic [FMT_W-1:0]   pixel_format;
      logic [STAMP_W-1:0] time_ns;
      logic [STAMP_W-1:0] guest_address;
   } meta_cmd_type;

   typedef struct packed {
      logic              push;
      logic              pop;
      logic [SLOT_W-1:0] push_slot;
   } order_cmd_type;

endpackage

// ----- rtl/bsq_channels.sv -----
// Request and response channel interfaces of the slot queue.
interface bsq_req_if;
   logic                          valid;
   logic                          ready;
   logic [bsq_pkg::OP_W-1:0]      operation;
   logic [bsq_pkg::IDX_W-1:0]     slot;
   logic [bsq_pkg::DIM_W-1:0]     width;
   logic [bsq_pkg::DIM_W-1:0]     height;
   logic [bsq_pkg::FMT_W-1:0]     pixel_format;
   logic [bsq_pkg::STAMP_W-1:0]   time_ns;
   logic [bsq_pkg::STAMP_W-1:0]   guest_address;

   modport source (
      output valid, operation, slot, width, height, pixel_format, time_ns, guest_address,
      input  ready
   );
   modport sink (
      input  valid, operation, slot, width, height, pixel_format, time_ns, guest_address,
      output ready
   );
endinterface

interface bsq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          ok;
   logic [bsq_pkg::SLOT_W-1:0]    slot_out;
   logic [bsq_pkg::STATE_W-1:0]   slot_state;
   logic [bsq_pkg::DIM_W-1:0]     width_out;
   logic [bsq_pkg::DIM_W-1:0]     height_out;
   logic [bsq_pkg::FMT_W-1:0]     format_out;
   logic [bsq_pkg::STAMP_W-1:0]   time_out;
   logic [bsq_pkg::STAMP_W-1:0]   address_out;
   logic [bsq_pkg::COUNT_W-1:0]   queued_count;

   modport source (
      output valid, ok, slot_out, slot_state, width_out, height_out, format_out,
             time_out, address_out, queued_count,
      input  ready
   );
   modport sink (
      input  valid, ok, slot_out, slot_state, width_out, height_out, format_out,
             time_out, address_out, queued_count,
      output ready
   );
endinterface

// ----- rtl/buffer_slot_queue_manager.sv -----
// An accepted item passes the input register, then the result register, before its result
// is offered; a stalled result stays in the result register until it is taken.
// Throughput: one item per cycle while the result side is ready; a stalled result holds the
// input register, and the input stalls with it. Slot state flops, free-slot priority encoder
// and the order memory with its prefetched head entry settle between the two registers.
// Reset (synchronous): slots free, order empty, metadata flags cleared; items taken at once.
module buffer_slot_queue_manager (
   input  logic       clock,
   input  logic       reset,
   bsq_req_if.sink    req_port,
   bsq_rsp_if.source  rsp_port
);
   import bsq_pkg::*;

   req_item_type       s1_ff;
   logic               s1_valid_ff;
   logic               adv;
   logic               req_ready;

   logic [STATE_W-1:0] state_ff [SLOTS];

   logic               rsp_valid_ff;
   logic               rsp_ok_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic [STATE_W-1:0] rsp_state_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic [SLOT_W-1:0]  idx;
   logic               slot_ok;
   logic [STATE_W-1:0] addr_state;
   logic               free_found;
   logic [SLOT_W-1:0]  free_idx;

   logic               res_ok;
   logic [SLOT_W-1:0]  res_slot;
   logic [STATE_W-1:0] res_state;
   logic               st_we;
   logic [SLOT_W-1:0]  st_addr;
   logic [STATE_W-1:0] st_val;
   logic               do_geom;
   logic               do_stamp;
   logic               do_get;
   logic               do_push;
   logic               do_pop;

   meta_cmd_type       meta_cmd;
   order_cmd_type      order_cmd;
   logic [SLOT_W-1:0]  head_slot;
   logic [COUNT_W-1:0] order_count;
   logic [COUNT_W-1:0] order_count_next;

   assign adv       = s1_valid_ff && (!rsp_valid_ff || rsp_port.ready);
   assign req_ready = !s1_valid_ff || adv;
   assign req_port.ready = req_ready;

   assign idx        = s1_ff.slot[SLOT_W-1:0];
   assign slot_ok    = s1_ff.slot < SLOT_LIMIT;
   assign addr_state = slot_ok ? state_ff[idx] : ST_FREE;

   // Lowest free slot wins.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (state_ff[i] == ST_FREE) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      res_ok    = 1'b0;
      res_slot  = '0;
      res_state = ST_FREE;
      st_we     = 1'b0;
      st_addr   = idx;
      st_val    = ST_FREE;
      do_geom   = 1'b0;
      do_stamp  = 1'b0;
      do_get    = 1'b0;
      do_push   = 1'b0;
      do_pop    = 1'b0;
      unique case (s1_ff.operation)
         OP_DEQUEUE: begin
            if (free_found) begin
               res_ok   = 1'b1;
               res_slot = free_idx;
               st_we    = 1'b1;
               st_addr  = free_idx;
               st_val   = ST_DEQUEUED;
               do_geom  = 1'b1;
            end
         end
         OP_QUEUE: begin
            if (slot_ok) begin
               res_slot = idx;
               if (addr_state == ST_DEQUEUED && order_count < COUNT_LIMIT) begin
                  res_ok   = 1'b1;
                  st_we    = 1'b1;
                  st_val   = ST_QUEUED;
                  do_stamp = 1'b1;
                  do_push  = 1'b1;
               end
            end
         end
         OP_CANCEL: begin
            if (slot_ok) begin
               res_slot = idx;
               if (addr_state == ST_DEQUEUED) begin
                  res_ok = 1'b1;
                  st_we  = 1'b1;
                  st_val = ST_FREE;
               end
            end
         end
         OP_ACQUIRE: begin
            if (order_count != '0) begin
               res_ok   = 1'b1;
               res_slot = head_slot;
               st_we    = 1'b1;
               st_addr  = head_slot;
               st_val   = ST_ACQUIRED;
               do_pop   = 1'b1;
            end
         end
         OP_RELEASE: begin
            if (slot_ok) begin
               res_slot = idx;
               if (addr_state == ST_ACQUIRED) begin
                  res_ok = 1'b1;
                  st_we  = 1'b1;
                  st_val = ST_FREE;
               end
            end
         end
         OP_GET: begin
            if (slot_ok) begin
               res_ok    = 1'b1;
               res_slot  = idx;
               res_state = addr_state;
               do_get    = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      meta_cmd.wr_geom       = adv && do_geom;
      meta_cmd.wr_stamp      = adv && do_stamp;
      meta_cmd.rd_en         = adv;
      meta_cmd.rd_get        = do_get;
      meta_cmd.addr          = do_geom ? free_idx : idx;
      meta_cmd.width         = s1_ff.width;
      meta_cmd.height        = s1_ff.height;
      meta_cmd.pixel_format  = s1_ff.pixel_format;
      meta_cmd.time_ns       = s1_ff.time_ns;
      meta_cmd.guest_address = s1_ff.guest_address;
      order_cmd.push         = adv && do_push;
      order_cmd.pop          = adv && do_pop;
      order_cmd.push_slot    = idx;
   end

   bsq_order_fifo u_order (
      .clock      (clock),
      .reset      (reset),
      .cmd        (order_cmd),
      .head_slot  (head_slot),
      .count      (order_count),
      .count_next (order_count_next)
   );

   bsq_meta_store u_meta (
      .clock       (clock),
      .reset       (reset),
      .cmd         (meta_cmd),
      .width_out   (rsp_port.width_out),
      .height_out  (rsp_port.height_out),
      .format_out  (rsp_port.format_out),
      .time_out    (rsp_port.time_out),
      .address_out (rsp_port.address_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_port.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.valid && req_ready) begin
         s1_ff.operation     <= req_port.operation;
         s1_ff.slot          <= req_port.slot;
         s1_ff.width         <= req_port.width;
         s1_ff.height        <= req_port.height;
         s1_ff.pixel_format  <= req_port.pixel_format;
         s1_ff.time_ns       <= req_port.time_ns;
         s1_ff.guest_address <= req_port.guest_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            state_ff[i] <= ST_FREE;
         end
      end else if (adv && st_we) begin
         state_ff[st_addr] <= st_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Hold the result while the consumer stalls.
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ok_ff    <= res_ok;
         rsp_slot_ff  <= res_slot;
         rsp_state_ff <= res_state;
         rsp_count_ff <= order_count_next;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.ok           = rsp_ok_ff;
   assign rsp_port.slot_out     = rsp_slot_ff;
   assign rsp_port.slot_state   = rsp_state_ff;
   assign rsp_port.queued_count = rsp_count_ff;

endmodule

// ----- rtl/bsq_order_fifo.sv -----
// Order of queued slots: a memory ring with a prefetched head entry.
module bsq_order_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  bsq_pkg::order_cmd_type        cmd,
   output logic [bsq_pkg::SLOT_W-1:0]    head_slot,
   output logic [bsq_pkg::COUNT_W-1:0]   count,
   output logic [bsq_pkg::COUNT_W-1:0]   count_next
);
   import bsq_pkg::*;

   logic [SLOT_W-1:0]  order_mem [ORDER_DEPTH];
   logic [SLOT_W-1:0]  head_ff, head_in;
   logic [SLOT_W-1:0]  tail_ff, tail_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SLOT_W-1:0]  head_data_ff;

   always_comb begin
      head_in  = cmd.pop  ? head_ff + SLOT_W'(1) : head_ff;
      tail_in  = cmd.push ? tail_ff + SLOT_W'(1) : tail_ff;
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Keep the entry at the next head ready; bypass a push that lands there.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         order_mem[tail_ff] <= cmd.push_slot;
      end
      if (cmd.push && (tail_ff == head_in)) begin
         head_data_ff <= cmd.push_slot;
      end else begin
         head_data_ff <= order_mem[head_in];
      end
   end

   assign head_slot  = head_data_ff;
   assign count      = count_ff;
   assign count_next = count_in;

endmodule

// ----- rtl/bsq_meta_store.sv -----
// Per-slot metadata memories with written flags and a registered, masked read port.
module bsq_meta_store (
   input  logic                          clock,
   input  logic                          reset,
   input  bsq_pkg::meta_cmd_type         cmd,
   output logic [bsq_pkg::DIM_W-1:0]     width_out,
   output logic [bsq_pkg::DIM_W-1:0]     height_out,
   output logic [bsq_pkg::FMT_W-1:0]     format_out,
   output logic [bsq_pkg::STAMP_W-1:0]   time_out,
   output logic [bsq_pkg::STAMP_W-1:0]   address_out
);
   import bsq_pkg::*;

   logic [DIM_W-1:0]   width_mem   [SLOTS];
   logic [DIM_W-1:0]   height_mem  [SLOTS];
   logic [FMT_W-1:0]   format_mem  [SLOTS];
   logic [STAMP_W-1:0] time_mem    [SLOTS];
   logic [STAMP_W-1:0] address_mem [SLOTS];

   logic [SLOTS-1:0]   geom_valid_ff;
   logic [SLOTS-1:0]   stamp_valid_ff;
   logic               sel_geom_ff;
   logic               sel_stamp_ff;

   logic [DIM_W-1:0]   rd_width_ff;
   logic [DIM_W-1:0]   rd_height_ff;
   logic [FMT_W-1:0]   rd_format_ff;
   logic [STAMP_W-1:0] rd_time_ff;
   logic [STAMP_W-1:0] rd_address_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_valid_ff  <= '0;
         stamp_valid_ff <= '0;
         sel_geom_ff    <= 1'b0;
         sel_stamp_ff   <= 1'b0;
      end else begin
         if (cmd.wr_geom) begin
            geom_valid_ff[cmd.addr] <= 1'b1;
         end
         if (cmd.wr_stamp) begin
            stamp_valid_ff[cmd.addr] <= 1'b1;
         end
         // A never-written entry reads as zero.
         if (cmd.rd_en) begin
            sel_geom_ff  <= cmd.rd_get && geom_valid_ff[cmd.addr];
            sel_stamp_ff <= cmd.rd_get && stamp_valid_ff[cmd.addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_geom) begin
         width_mem[cmd.addr]  <= cmd.width;
         height_mem[cmd.addr] <= cmd.height;
         format_mem[cmd.addr] <= cmd.pixel_format;
      end
      if (cmd.wr_stamp) begin
         time_mem[cmd.addr]    <= cmd.time_ns;
         address_mem[cmd.addr] <= cmd.guest_address;
      end
      if (cmd.rd_en) begin
         rd_width_ff   <= width_mem[cmd.addr];
         rd_height_ff  <= height_mem[cmd.addr];
         rd_format_ff  <= format_mem[cmd.addr];
         rd_time_ff    <= time_mem[cmd.addr];
         rd_address_ff <= address_mem[cmd.addr];
      end
   end

   assign width_out   = sel_geom_ff  ? rd_width_ff   : '0;
   assign height_out  = sel_geom_ff  ? rd_height_ff  : '0;
   assign format_out  = sel_geom_ff  ? rd_format_ff  : '0;
   assign time_out    = sel_stamp_ff ? rd_time_ff    : '0;
   assign address_out = sel_stamp_ff ? rd_address_ff : '0;

endmodule

// ----- test/tb_buffer_slot_queue_manager.sv -----
// Self-checking testbench for the frame-buffer slot queue manager.
module tb_buffer_slot_queue_manager;
   import bsq_pkg::*;

   typedef struct {
      logic [STATE_W-1:0] state [SLOTS];
      logic [DIM_W-1:0]   wid [SLOTS];
      logic [DIM_W-1:0]   hgt [SLOTS];
      logic [FMT_W-1:0]   fmt [SLOTS];
      logic [STAMP_W-1:0] stamp [SLOTS];
      logic [STAMP_W-1:0] addr [SLOTS];
      logic [SLOT_W-1:0]  order [ORDER_DEPTH];
      logic [SLOT_W-1:0]  head;
      logic [SLOT_W-1:0]  tail;
      logic [COUNT_W-1:0] count;
   } slot_book_type;

   typedef struct packed {
      logic               ok;
      logic [SLOT_W-1:0]  slot_out;
      logic [STATE_W-1:0] slot_state;
      logic [DIM_W-1:0]   width_out;
      logic [DIM_W-1:0]   height_out;
      logic [FMT_W-1:0]   format_out;
      logic [STAMP_W-1:0] time_out;
      logic [STAMP_W-1:0] address_out;
      logic [COUNT_W-1:0] queued_count;
   } slot_report_type;

   logic clock = 1'b0;
   logic reset;

   bsq_req_if req_bus ();
   bsq_rsp_if rsp_bus ();

   buffer_slot_queue_manager dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   slot_book_type   plan_book;
   slot_book_type   live_book;
   req_item_type    pending_items [$];
   slot_report_type expected_reports [$];
   req_item_type    offered;
   int              fault_count = 0;
   int              send_idle_pct = 0;
   int              stall_pct = 0;
   bit              burst_armed = 1'b0;
   bit              burst_done = 1'b0;
   int              burst_left = 0;

   always #5 clock = ~clock;

   function automatic void clear_book(ref slot_book_type b);
      for (int i = 0; i < SLOTS; i++) begin
         b.state[i] = ST_FREE;
         b.wid[i]   = '0;
         b.hgt[i]   = '0;
         b.fmt[i]   = '0;
         b.stamp[i] = '0;
         b.addr[i]  = '0;
      end
      b.head  = '0;
      b.tail  = '0;
      b.count = '0;
   endfunction

   // Apply one operation to a book of slots and work out the report it gives.
   function automatic void apply_op(ref slot_book_type b, input req_item_type it,
                                    output slot_report_type r);
      logic              in_range;
      logic [SLOT_W-1:0] idx;
      logic [SLOT_W-1:0] popped;
      bit                found;
      r        = '0;
      in_range = it.slot < SLOT_LIMIT;
      idx      = it.slot[SLOT_W-1:0];
      found    = 1'b0;
      case (it.operation)
         OP_DEQUEUE: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!found && b.state[i] == ST_FREE) begin
                  found      = 1'b1;
                  b.state[i] = ST_DEQUEUED;
                  b.wid[i]   = it.width;
                  b.hgt[i]   = it.height;
                  b.fmt[i]   = it.pixel_format;
                  r.ok       = 1'b1;
                  r.slot_out = SLOT_W'(i);
               end
            end
         end
         OP_QUEUE: begin
            if (in_range) begin
               r.slot_out = idx;
               if (b.state[idx] == ST_DEQUEUED && b.count < COUNT_LIMIT) begin
                  b.state[idx]  = ST_QUEUED;
                  b.stamp[idx]  = it.time_ns;
                  b.addr[idx]   = it.guest_address;
                  b.order[b.tail] = idx;
                  b.tail        = b.tail + 1'b1;
                  b.count       = b.count + 1'b1;
                  r.ok          = 1'b1;
               end
            end
         end
         OP_CANCEL: begin
            if (in_range) begin
               r.slot_out = idx;
               if (b.state[idx] == ST_DEQUEUED) begin
                  b.state[idx] = ST_FREE;
                  r.ok         = 1'b1;
               end
            end
         end
         OP_ACQUIRE: begin
            if (b.count != 0) begin
               popped          = b.order[b.head];
               b.head          = b.head + 1'b1;
               b.count         = b.count - 1'b1;
               b.state[popped] = ST_ACQUIRED;
               r.ok            = 1'b1;
               r.slot_out      = popped;
            end
         end
         OP_RELEASE: begin
            if (in_range) begin
               r.slot_out = idx;
               if (b.state[idx] == ST_ACQUIRED) begin
                  b.state[idx] = ST_FREE;
                  r.ok         = 1'b1;
               end
            end
         end
         OP_GET: begin
            if (in_range) begin
               r.ok          = 1'b1;
               r.slot_out    = idx;
               r.slot_state  = b.state[idx];
               r.width_out   = b.wid[idx];
               r.height_out  = b.hgt[idx];
               r.format_out  = b.fmt[idx];
               r.time_out    = b.stamp[idx];
               r.address_out = b.addr[idx];
            end
         end
         default: ;
      endcase
      r.queued_count = b.count;
   endfunction

   function automatic logic [DIM_W-1:0] pick16();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return DIM_W'($urandom);
      endcase
   endfunction

   function automatic logic [STAMP_W-1:0] pick64();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_item_type make_cmd(logic [OP_W-1:0] op, int slot,
                                             logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                                             logic [FMT_W-1:0] f, logic [STAMP_W-1:0] t,
                                             logic [STAMP_W-1:0] a);
      req_item_type it;
      it.operation     = op;
      it.slot          = IDX_W'(slot);
      it.width         = w;
      it.height        = h;
      it.pixel_format  = f;
      it.time_ns       = t;
      it.guest_address = a;
      return it;
   endfunction

   // Mostly legal commands aimed at slots in the right state; grow biases
   // towards dequeue and queue so the slots and the order fill up.
   function automatic req_item_type make_random_cmd(int grow);
      req_item_type       it;
      int                 cand [$];
      logic [STATE_W-1:0] want;
      bit                 aimed;
      it = make_cmd(OP_W'($urandom_range(0, 7)), $urandom_range(0, 127), pick16(),
                    pick16(), FMT_W'(pick16()), pick64(), pick64());
      if ($urandom_range(0, 99) < 15)
         return it;
      aimed = 1'b0;
      if ($urandom_range(0, 99) < grow) begin
         it.operation = $urandom_range(0, 1) ? OP_QUEUE : OP_DEQUEUE;
      end else begin
         case ($urandom_range(0, 3))
            0: it.operation = OP_CANCEL;
            1: it.operation = OP_ACQUIRE;
            2: it.operation = OP_RELEASE;
            default: it.operation = OP_GET;
         endcase
      end
      case (it.operation)
         OP_QUEUE, OP_CANCEL: begin
            want  = ST_DEQUEUED;
            aimed = 1'b1;
         end
         OP_RELEASE: begin
            want  = ST_ACQUIRED;
            aimed = 1'b1;
         end
         default: want = ST_FREE;
      endcase
      it.slot = IDX_W'($urandom_range(0, SLOTS - 1));
      if (aimed) begin
         for (int i = 0; i < SLOTS; i++)
            if (plan_book.state[i] == want)
               cand.insert(cand.size(), i);
         if (cand.size() != 0 && $urandom_range(0, 9) != 0)
            it.slot = IDX_W'(cand[$urandom_range(0, cand.size() - 1)]);
      end
      return it;
   endfunction

   function automatic void add_item(req_item_type it);
      slot_report_type scratch;
      apply_op(plan_book, it, scratch);
      pending_items.insert(pending_items.size(), it);
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fault_count++;
      end
   endfunction

   // Driver: predict on acceptance, then offer the next item or idle.
   always @(posedge clock) begin
      slot_report_type r;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            apply_op(live_book, offered, r);
            expected_reports.insert(expected_reports.size(), r);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               offered = pending_items[0];
               pending_items.delete(0);
               req_bus.operation     <= offered.operation;
               req_bus.slot          <= offered.slot;
               req_bus.width         <= offered.width;
               req_bus.height        <= offered.height;
               req_bus.pixel_format  <= offered.pixel_format;
               req_bus.time_ns       <= offered.time_ns;
               req_bus.guest_address <= offered.guest_address;
               req_bus.valid         <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off when armed.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (burst_armed && !burst_done) begin
            burst_done = 1'b1;
            burst_left = 300;
         end
         if (burst_left > 0) begin
            burst_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      slot_report_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_reports.size() == 0) begin
            $error("result item with no expectation waiting");
            fault_count++;
         end else begin
            want = expected_reports[0];
            expected_reports.delete(0);
            check_field("ok", want.ok, rsp_bus.ok);
            check_field("slot_out", want.slot_out, rsp_bus.slot_out);
            check_field("slot_state", want.slot_state, rsp_bus.slot_state);
            check_field("width_out", want.width_out, rsp_bus.width_out);
            check_field("height_out", want.height_out, rsp_bus.height_out);
            check_field("format_out", want.format_out, rsp_bus.format_out);
            check_field("time_out", want.time_out, rsp_bus.time_out);
            check_field("address_out", want.address_out, rsp_bus.address_out);
            check_field("queued_count", want.queued_count, rsp_bus.queued_count);
         end
      end
   end

   task automatic run_random(int n, int idle, int stall, int grow);
      send_idle_pct = idle;
      stall_pct     = stall;
      for (int i = 0; i < n; i++)
         add_item(make_random_cmd(grow));
      while (pending_items.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      req_bus.valid         = 1'b0;
      req_bus.operation     = '0;
      req_bus.slot          = '0;
      req_bus.width         = '0;
      req_bus.height        = '0;
      req_bus.pixel_format  = '0;
      req_bus.time_ns       = '0;
      req_bus.guest_address = '0;
      rsp_bus.ready         = 1'b0;
      reset                 = 1'b1;
      clear_book(plan_book);
      clear_book(live_book);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, every operation, empty order, bad slots, wrong states.
      add_item(make_cmd(OP_DEQUEUE, 0, '1, '0, '1, '0, '0));
      add_item(make_cmd(OP_DEQUEUE, 0, '0, '1, '0, '0, '0));
      add_item(make_cmd(OP_QUEUE, 0, '0, '0, '0, '1, '0));
      add_item(make_cmd(OP_QUEUE, 1, '0, '0, '0, '0, '1));
      add_item(make_cmd(OP_GET, 0, '0, '0, '0, '0, '0));
      add_item(make_cmd(OP_GET, 1, '1, '1, '1, '1, '1));
      add_item(make_cmd(OP_QUEUE, 0, '0, '0, '0, '0, '0));
      add_item(make_cmd(OP_CANCEL, 0, '0, '0, '0, '0, '0));
      add_item(make_cmd(OP_ACQUIRE, 0, '0, '0, '0, '0, '0));
      add_item(make_cmd(OP_ACQUIRE, 0, '0, '0, '0, '0, '0));
      add_item(make_cmd(OP_ACQUIRE, 0, '0, '0, '0, '0, '0));
      add_item(make_cmd(OP_RELEASE, 0, '0, '0, '0, '0, '0));
      add_item(make_cmd(OP_RELEASE, 0, '0, '0, '0, '0, '0));
      add_item(make_cmd(OP_GET, 63, '0, '0, '0, '0, '0));
      add_item(make_cmd(OP_GET, 64, '0, '0, '0, '0, '0));
      add_item(make_cmd(OP_QUEUE, 127, '0, '0, '0, '1, '1));
      add_item(make_cmd(OP_CANCEL, 64, '0, '0, '0, '0, '0));
      add_item(make_cmd(OP_RELEASE, 100, '0, '0, '0, '0, '0));
      add_item(make_cmd(3'd6, 5, '1, '1, '1, '1, '1));
      add_item(make_cmd(3'd7, 127, '1, '1, '1, '1, '1));
      // Re-dequeue of slot 0 keeps its old stamp and address.
      add_item(make_cmd(OP_DEQUEUE, 0, 16'h1234, 16'h5678, 8'h5a, '0, '0));
      add_item(make_cmd(OP_GET, 0, '0, '0, '0, '0, '0));
      add_item(make_cmd(OP_CANCEL, 0, '0, '0, '0, '0, '0));
      add_item(make_cmd(OP_GET, 0, '0, '0, '0, '0, '0));
      while (pending_items.size() != 0)
         @(negedge clock);

      run_random(250, 0, 0, 75);
      run_random(250, 53, 0, 30);
      run_random(250, 0, 53, 75);
      run_random(250, 10, 10, 30);
      // Long receiver hold-off while the sender keeps offering: the block backs up.
      burst_armed = 1'b1;
      run_random(100, 0, 0, 50);

      while (expected_reports.size() != 0 || req_bus.valid)
         @(negedge clock);
      repeat (10) @(negedge clock);
      if (fault_count == 0 && expected_reports.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
